FILE: rtl/core/ihg_pkg.sv
package ihg_pkg;

  localparam int HDR_BYTES = 42;
  localparam int HDR_W     = 8 * HDR_BYTES;
  localparam int POS_W     = 6;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  IP_VER_IHL     = 8'h45;
  localparam logic [15:0] IP_FLAGS_DF    = 16'h4000;
  localparam logic [7:0]  PROTO_UDP      = 8'd17;
  localparam logic [7:0]  PROTO_ICMP     = 8'd1;
  localparam logic [7:0]  ICMP_ECHO_REQ  = 8'd8;
  localparam logic [15:0] UDP_HDR_LEN    = 16'd8;
  localparam logic [15:0] IP_HDR_LEN     = 16'd20;
  localparam logic [15:0] ICMP_MSG_LEN   = 16'd64;

  localparam logic [7:0]  TTL_RESET      = 8'd255;
  localparam logic [15:0] ECHO_ID_RESET  = 16'h0742;

  localparam logic KIND_UDP  = 1'b0;
  localparam logic KIND_ICMP = 1'b1;

  localparam int          ADDR_W      = 3;
  localparam logic        REG_TTL     = 1'b0;
  localparam logic        REG_ECHO_ID = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [47:0] dst_mac;
    logic [47:0] src_mac;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] payload_len;
  } in_word_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  time_to_live;
    logic [15:0] echo_identifier;
  } cfg_t;

endpackage

FILE: rtl/core/ihg_hdr_pipe.sv
module ihg_hdr_pipe (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ihg_pkg::cfg_t         cfg,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  ihg_pkg::in_word_t     in_word,
  output logic                  hdr_valid,
  input  logic                  hdr_stall,
  output logic [ihg_pkg::HDR_W-1:0] hdr
);
  import ihg_pkg::*;

  logic v1_r, v2_r, v3_r;
  logic v1_nxt, v2_nxt, v3_nxt;
  logic adv1, adv2, adv3;

  in_word_t    req1_r, req2_r;
  logic [15:0] total2_r, l4len2_r, icsum2_r;
  logic [7:0]  proto2_r;
  logic [17:0] suma2_r, sumb2_r;
  logic [HDR_W-1:0] hdr3_r;

  logic [15:0] l4len_c, total_c, icsum_c;
  logic [7:0]  proto_c;
  logic [17:0] suma_c, sumb_c;
  logic [16:0] icsum_raw;
  logic [18:0] sum_c;
  logic [16:0] fold1_c;
  logic [15:0] fold2_c, ipsum_c;
  logic [63:0] l4_c;

  assign adv3     = !v3_r || !hdr_stall;
  assign adv2     = !v2_r || adv3;
  assign adv1     = !v1_r || adv2;
  assign in_stall = !adv1;

  assign v1_nxt = adv1 ? in_valid : v1_r;
  assign v2_nxt = adv2 ? v1_r : v2_r;
  assign v3_nxt = adv3 ? v2_r : v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_comb begin
    proto_c   = (req1_r.kind == KIND_ICMP) ? PROTO_ICMP : PROTO_UDP;
    l4len_c   = (req1_r.kind == KIND_ICMP) ? ICMP_MSG_LEN
                                           : 16'(UDP_HDR_LEN + req1_r.payload_len);
    total_c   = 16'(IP_HDR_LEN + l4len_c);
    suma_c    = 18'({IP_VER_IHL, 8'h00}) + 18'(IP_FLAGS_DF) + 18'(total_c)
              + 18'({cfg.time_to_live, proto_c});
    sumb_c    = 18'(req1_r.src_ip[31:16]) + 18'(req1_r.src_ip[15:0])
              + 18'(req1_r.dst_ip[31:16]) + 18'(req1_r.dst_ip[15:0]);
    icsum_raw = 17'({ICMP_ECHO_REQ, 8'h00}) + 17'(cfg.echo_identifier);
    icsum_c   = ~16'(icsum_raw[15:0] + 16'(icsum_raw[16]));
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      req1_r <= in_word;
    end
    if (adv2) begin
      req2_r   <= req1_r;
      total2_r <= total_c;
      l4len2_r <= l4len_c;
      proto2_r <= proto_c;
      suma2_r  <= suma_c;
      sumb2_r  <= sumb_c;
      icsum2_r <= icsum_c;
    end
    if (adv3) begin
      hdr3_r <= {req2_r.dst_mac, req2_r.src_mac, ETHERTYPE_IPV4,
                 IP_VER_IHL, 8'h00, total2_r, 16'h0000, IP_FLAGS_DF,
                 cfg.time_to_live, proto2_r, ipsum_c,
                 req2_r.src_ip, req2_r.dst_ip, l4_c};
    end
  end

  always_comb begin
    sum_c   = 19'(suma2_r) + 19'(sumb2_r);
    fold1_c = 17'(sum_c[15:0]) + 17'(sum_c[18:16]);
    fold2_c = 16'(fold1_c[15:0] + 16'(fold1_c[16]));
    ipsum_c = ~fold2_c;
    if (req2_r.kind == KIND_ICMP) begin
      l4_c = {ICMP_ECHO_REQ, 8'h00, icsum2_r, cfg.echo_identifier, 16'h0000};
    end else begin
      l4_c = {req2_r.src_port, req2_r.dst_port, l4len2_r, 16'h0000};
    end
  end

  assign hdr_valid = v3_r;
  assign hdr       = hdr3_r;

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && hdr_stall) |=> (v3_r && $stable(hdr3_r)))
    else $error("stalled header left the last stage");

  a_full_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
    (v1_r && v2_r && v3_r && hdr_stall) |-> in_stall)
    else $error("full pipeline accepted a word");

  a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> v1_r)
    else $error("accepted word did not enter the first stage");

endmodule

FILE: rtl/core/ipv4_udp_icmp_header_generator.sv
// Ethernet, IPv4 and UDP or ICMP echo request header generator.
// Each word accepted on the input channel (valid high, stall low) describes one
// frame. The block returns the 42-byte header of that frame on the output
// channel, one byte per word in wire order, with last_byte set on the final
// byte. When the output is idle, an accepted word passes through the three
// pipeline stages, which compute the lengths and the checksums, and is then
// loaded into a 42-byte shift register that sends the bytes out. The next
// header is loaded as the final byte of the current frame is taken, and up
// to three more words queue in the stages. When the receiver raises out_stall
// the current byte holds and the stages fill, after which in_stall rises.
// Reset empties every stage and sets the TTL to 255 and the echo identifier
// to 0x0742. The APB port holds the TTL at byte address 0 and the echo
// identifier at address 4; the user must see that it is written only while
// no frame is in flight, as the block itself does not enforce it.
module ipv4_udp_icmp_header_generator (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  ihg_pkg::in_word_t           in_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output ihg_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ihg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import ihg_pkg::*;

  logic [7:0]  ttl_r;
  logic [15:0] echo_id_r;
  cfg_t        cfg;
  logic        wr_en;

  logic             hdr_valid, hdr_stall;
  logic [HDR_W-1:0] hdr;

  logic             busy_r, busy_nxt;
  logic [POS_W-1:0] cnt_r, cnt_nxt;
  logic [HDR_W-1:0] sh_r, sh_nxt;
  logic             out_acc, is_last, load;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r     <= TTL_RESET;
      echo_id_r <= ECHO_ID_RESET;
    end else if (wr_en) begin
      unique case (paddr[2])
        REG_TTL:     ttl_r     <= pwdata[7:0];
        REG_ECHO_ID: echo_id_r <= pwdata[15:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_TTL:     prdata = {24'h0, ttl_r};
      REG_ECHO_ID: prdata = {16'h0, echo_id_r};
      default:     prdata = 32'h0;
    endcase
  end

  assign cfg.time_to_live    = ttl_r;
  assign cfg.echo_identifier = echo_id_r;

  ihg_hdr_pipe u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .hdr_valid (hdr_valid),
    .hdr_stall (hdr_stall),
    .hdr       (hdr)
  );

  assign out_acc   = busy_r && !out_stall;
  assign is_last   = (cnt_r == POS_W'(HDR_BYTES - 1));
  assign load      = hdr_valid && (!busy_r || (out_acc && is_last));
  assign hdr_stall = !load;

  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    sh_nxt   = sh_r;
    if (load) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sh_nxt   = hdr;
    end else if (out_acc) begin
      busy_nxt = !is_last;
      cnt_nxt  = cnt_r + 1'b1;
      sh_nxt   = {sh_r[HDR_W-9:0], 8'h00};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sh_r <= sh_nxt;
  end

  assign out_valid          = busy_r;
  assign out_word.data_byte = sh_r[HDR_W-1 -: 8];
  assign out_word.last_byte = is_last;

  a_frame_continues: assert property (@(posedge clk) disable iff (!rst_n)
    (busy_r && !out_stall && !is_last) |=> busy_r)
    else $error("frame ended before its final byte");

  a_end_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $fell(busy_r)) |-> $past(out_word.last_byte))
    else $error("output went idle without a final byte");

  a_idle_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (hdr_valid && !busy_r) |=> (busy_r && cnt_r == '0))
    else $error("ready header not loaded into an idle serializer");

endmodule

FILE: test/header_byte_checker.sv
`timescale 1ns / 100ps

module header_byte_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  ihg_pkg::in_word_t           in_word,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  ihg_pkg::out_word_t          out_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ihg_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  input  logic [31:0]                 prdata,
  input  logic                        pready,
  output int                          error_count,
  output int                          pending_bytes
);
  import ihg_pkg::*;

  localparam logic [ADDR_W-1:0] TTL_ADDR     = {REG_TTL, 2'b00};
  localparam logic [ADDR_W-1:0] ECHO_ID_ADDR = {REG_ECHO_ID, 2'b00};
  localparam int                PRINT_LIMIT  = 100;

  logic [7:0]  ttl_value;
  logic [15:0] echo_id_value;
  out_word_t   expected_bytes[$];

  initial begin
    error_count   = 0;
    pending_bytes = 0;
  end

  task automatic report_mismatch(input string what);
    error_count++;
    if (error_count <= PRINT_LIMIT) begin
      $display("%0t ns: %s", $time, what);
    end
  endtask

  function automatic logic [15:0] inverted_ones_sum(input logic [31:0] sum);
    logic [31:0] s;
    s = {16'h0000, sum[15:0]} + {16'h0000, sum[31:16]};
    s = {16'h0000, s[15:0]} + {16'h0000, s[31:16]};
    return ~s[15:0];
  endfunction

  // Builds the whole frame header, the first byte on the wire in the top bits.
  function automatic logic [HDR_W-1:0] frame_header(input in_word_t w,
                                                    input logic [7:0] ttl,
                                                    input logic [15:0] echo_id);
    logic [15:0] l4_len;
    logic [15:0] total_len;
    logic [7:0]  proto;
    logic [31:0] sum;
    logic [15:0] ip_csum;
    logic [15:0] icmp_csum;
    logic [63:0] l4_header;
    l4_len    = (w.kind == KIND_ICMP) ? ICMP_MSG_LEN : UDP_HDR_LEN + w.payload_len;
    total_len = IP_HDR_LEN + l4_len;
    proto     = (w.kind == KIND_ICMP) ? PROTO_ICMP : PROTO_UDP;
    sum = 32'({IP_VER_IHL, 8'h00}) + 32'(total_len) + 32'(IP_FLAGS_DF) + 32'({ttl, proto})
        + 32'(w.src_ip[31:16]) + 32'(w.src_ip[15:0])
        + 32'(w.dst_ip[31:16]) + 32'(w.dst_ip[15:0]);
    ip_csum   = inverted_ones_sum(sum);
    icmp_csum = inverted_ones_sum(32'({ICMP_ECHO_REQ, 8'h00}) + 32'(echo_id));
    if (w.kind == KIND_ICMP) begin
      l4_header = {ICMP_ECHO_REQ, 8'h00, icmp_csum, echo_id, 16'h0000};
    end else begin
      l4_header = {w.src_port, w.dst_port, l4_len, 16'h0000};
    end
    return {w.dst_mac, w.src_mac, ETHERTYPE_IPV4,
            IP_VER_IHL, 8'h00, total_len, 16'h0000, IP_FLAGS_DF, ttl, proto, ip_csum,
            w.src_ip, w.dst_ip, l4_header};
  endfunction

  always @(posedge clk) begin
    logic [HDR_W-1:0] header;
    out_word_t        want;
    logic [31:0]      read_value;
    if (!rst_n) begin
      ttl_value     = TTL_RESET;
      echo_id_value = ECHO_ID_RESET;
      expected_bytes.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("unexpected header word %h", out_word));
        end else begin
          want = expected_bytes.pop_front();
          if (out_word.data_byte !== want.data_byte) begin
            report_mismatch($sformatf("data_byte %h, expected %h",
                                      out_word.data_byte, want.data_byte));
          end
          if (out_word.last_byte !== want.last_byte) begin
            report_mismatch($sformatf("last_byte %b, expected %b",
                                      out_word.last_byte, want.last_byte));
          end
        end
      end
      if (in_valid && !in_stall) begin
        header = frame_header(in_word, ttl_value, echo_id_value);
        for (int k = 0; k < HDR_BYTES; k++) begin
          want.data_byte = header[HDR_W-1-8*k -: 8];
          want.last_byte = (k == HDR_BYTES - 1);
          expected_bytes.push_back(want);
        end
      end
      if (psel && penable && pready) begin
        if (pwrite) begin
          case (paddr)
            TTL_ADDR:     ttl_value = pwdata[7:0];
            ECHO_ID_ADDR: echo_id_value = pwdata[15:0];
            default: ;
          endcase
        end else begin
          read_value = (paddr == ECHO_ID_ADDR) ? {16'h0000, echo_id_value}
                                               : {24'h000000, ttl_value};
          if (prdata !== read_value) begin
            report_mismatch($sformatf("register read at %0d gave %h, expected %h",
                                      paddr, prdata, read_value));
          end
        end
      end
    end
    pending_bytes <= expected_bytes.size();
  end

endmodule

FILE: test/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import ihg_pkg::*;

  localparam int                CYCLE_LIMIT  = 1_000_000;
  localparam logic [ADDR_W-1:0] TTL_ADDR     = {REG_TTL, 2'b00};
  localparam logic [ADDR_W-1:0] ECHO_ID_ADDR = {REG_ECHO_ID, 2'b00};

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  in_word_t          in_word;
  logic              out_valid;
  logic              out_stall;
  out_word_t         out_word;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  int                error_count;
  int                pending_bytes;
  int                cycles = 0;
  logic              quiet = 1'b0;

  ipv4_udp_icmp_header_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  header_byte_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_word       (in_word),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_word      (out_word),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .error_count   (error_count),
    .pending_bytes (pending_bytes)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    out_stall <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(posedge clk);
        out_stall <= 1'b0;
      end
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(50, 150)) @(posedge clk);
      end else begin
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  function automatic in_word_t fill_word(input logic kind, input logic [47:0] pattern,
                                         input logic [15:0] len);
    in_word_t w;
    w.kind        = kind;
    w.dst_mac     = pattern;
    w.src_mac     = ~pattern;
    w.src_ip      = pattern[31:0];
    w.dst_ip      = pattern[47:16];
    w.src_port    = pattern[15:0];
    w.dst_port    = ~pattern[15:0];
    w.payload_len = len;
    return w;
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    int       pick;
    pick          = $urandom_range(0, 9);
    w.kind        = 1'($urandom_range(0, 1));
    w.dst_mac     = {16'($urandom), 32'($urandom)};
    w.src_mac     = {16'($urandom), 32'($urandom)};
    w.src_ip      = $urandom;
    w.dst_ip      = $urandom;
    w.src_port    = 16'($urandom);
    w.dst_port    = 16'($urandom);
    if (pick < 7) begin
      w.payload_len = 16'($urandom_range(0, 65507));
    end else if (pick < 9) begin
      w.payload_len = 16'($urandom_range(0, 64));
    end else begin
      w.payload_len = 16'($urandom);
    end
    return w;
  endfunction

  task automatic apb_access(input logic write, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= write;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] ttl, input logic [15:0] echo_id);
    apb_access(1'b1, TTL_ADDR, {24'h000000, ttl});
    apb_access(1'b1, ECHO_ID_ADDR, {16'h0000, echo_id});
    apb_access(1'b0, TTL_ADDR, 32'h0);
    apb_access(1'b0, ECHO_ID_ADDR, 32'h0);
  endtask

  task automatic send_frame(input in_word_t w, input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(negedge clk); while (in_stall);
    @(posedge clk);
  endtask

  // Lowers valid in the step of the last acceptance, then waits until the
  // checker expects no more bytes, so the pipeline is empty.
  task automatic finish_phase();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_bytes != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_random(input int count, input logic gaps);
    int gap;
    for (int i = 0; i < count; i++) begin
      gap = (gaps && $urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : 0;
      send_frame(random_word(), gap);
    end
    finish_phase();
  endtask

  task automatic send_edge_kinds();
    send_frame(fill_word(KIND_UDP, '1, 16'hffff), 0);
    send_frame(fill_word(KIND_ICMP, '0, 16'h0000), 0);
    send_frame(fill_word(KIND_ICMP, '1, 16'hffff), 0);
    finish_phase();
  endtask

  initial begin
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_word  <= '0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_frame(fill_word(KIND_UDP, '0, 16'd0), 0);
    send_frame(fill_word(KIND_UDP, '1, 16'hffff), 0);
    send_frame(fill_word(KIND_UDP, 48'haaaa_aaaa_aaaa, 16'd65507), 3);
    send_frame(fill_word(KIND_UDP, 48'h5555_5555_5555, 16'd65527), 0);
    send_frame(fill_word(KIND_UDP, 48'h0123_4567_89ab, 16'd65528), 0);
    send_frame(fill_word(KIND_ICMP, '0, 16'd0), 0);
    send_frame(fill_word(KIND_ICMP, '1, 16'hffff), 5);
    send_frame(fill_word(KIND_ICMP, 48'haaaa_aaaa_aaaa, 16'd1234), 0);
    send_frame(fill_word(KIND_UDP, 48'hffff_ffff_0000, 16'd1), 0);
    finish_phase();

    set_config(8'h00, 16'h0000);
    send_edge_kinds();
    set_config(8'hff, 16'hffff);
    send_edge_kinds();
    set_config(8'h80, 16'hf7ff);
    send_edge_kinds();
    set_config(8'h01, 16'hf800);
    send_edge_kinds();

    for (int p = 0; p < 5; p++) begin
      set_config(8'($urandom), 16'($urandom));
      send_random(55, 1'b1);
    end

    quiet = 1'b1;
    set_config(8'($urandom), 16'($urandom));
    send_random(25, 1'b0);

    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
